[hdl/hnwm_pkg.sv]
// ---------------------------------------------------------------------------
// hnwm_pkg
// Shared types, constants and helpers for the nearest-word matcher.
// ---------------------------------------------------------------------------
package hnwm_pkg;

    localparam int DICT_DEPTH   = 64;
    localparam int MAX_WORD_LEN = 8;

    localparam int WORD_W   = 64;
    localparam int LEN_W    = 4;
    localparam int BYTES    = WORD_W / 8;
    localparam int ADDR_W   = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
    localparam int CNT_W    = $clog2(DICT_DEPTH + 1);
    localparam int ENTRY_W  = WORD_W + LEN_W;

    // Request codes
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_SINGLE  = 3'd1;
    localparam logic [2:0] ST_SEVERAL = 3'd2;
    localparam logic [2:0] ST_LOADED  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [WORD_W-1:0] word_chars;
        logic [LEN_W-1:0]  word_len;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] match_word;
        logic [LEN_W-1:0]  match_len;
        logic [2:0]        status;
        logic              last;
    } result_t;

    typedef struct packed {
        logic             cand;
        logic [LEN_W-1:0] agree;
    } score_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = (len > LEN_W'(MAX_WORD_LEN)) ? LEN_W'(MAX_WORD_LEN) : len;
        return r;
    endfunction

    // Lower-case bytes below len, zero the rest.
    function automatic logic [WORD_W-1:0] norm_word(input logic [WORD_W-1:0] w,
                                                    input logic [LEN_W-1:0]  len);
        logic [WORD_W-1:0] r;
        logic [7:0]        b;
        r = '0;
        for (int i = 0; i < BYTES; i++)
        begin
            b = w[8*i +: 8];
            if (b >= 8'h41 && b <= 8'h5A)
            begin
                b = b + 8'h20;
            end
            if (LEN_W'(i) < len)
            begin
                r[8*i +: 8] = b;
            end
        end
        return r;
    endfunction

endpackage

[hdl/hnwm_ram.sv]
// ---------------------------------------------------------------------------
// hnwm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module hnwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/hnwm_score.sv]
// ---------------------------------------------------------------------------
// hnwm_score
// Shared compare unit: agreement count of one stored entry against the query,
// and the candidate test (equal lengths, twice the mismatches within the length).
// ---------------------------------------------------------------------------
module hnwm_score
    import hnwm_pkg::*;
(
    input  logic [WORD_W-1:0] q_word,
    input  logic [LEN_W-1:0]  q_len,
    input  logic [WORD_W-1:0] e_word,
    input  logic [LEN_W-1:0]  e_len,
    output score_t            score
);

    logic [LEN_W-1:0] agree;
    logic [LEN_W-1:0] mism;

    always_comb
    begin
        agree = '0;
        for (int i = 0; i < BYTES; i++)
        begin
            if (LEN_W'(i) < q_len && q_word[8*i +: 8] == e_word[8*i +: 8])
            begin
                agree = agree + LEN_W'(1);
            end
        end
        mism        = q_len - agree;
        score.agree = agree;
        score.cand  = (e_len == q_len) && ({mism, 1'b0} <= {1'b0, q_len});
    end

endmodule

[hdl/hamming_nearest_word_match.sv]
// ---------------------------------------------------------------------------
// hamming_nearest_word_match
// Dictionary of lower-cased words with nearest-match lookup by agreement.
// ---------------------------------------------------------------------------
// A transfer in is taken when start is high and busy is low. Load and clear
// give a single result that appears on the next cycle while busy stays low,
// so a new item can follow at once. A query walks the stored entries through
// one dictionary read port and one compare unit, one entry per cycle: a first
// pass finds the best agreement and how many entries tie on it, and if any
// entry is a candidate a second pass emits the tied entries in load order.
// A query holds busy until its passes are done (busy stays low when the
// dictionary is empty). Each result is shown for one cycle with result_valid
// high and cannot be held off; result.last marks the final one of an item.
// ---------------------------------------------------------------------------
module hamming_nearest_word_match
    import hnwm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  req_t    req,
    output logic    result_valid,
    output result_t result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]        state_reg,     state_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              rd_vld_reg,    rd_vld_next;
    logic              best_vld_reg,  best_vld_next;
    logic [LEN_W-1:0]  best_reg,      best_next;
    logic [CNT_W-1:0]  hits_reg,      hits_next;
    logic [CNT_W-1:0]  emitted_reg,   emitted_next;
    logic              out_vld_reg,   out_vld_next;
    result_t           out_reg,       out_next;
    logic [WORD_W-1:0] q_word_reg,    q_word_next;
    logic [LEN_W-1:0]  q_len_reg,     q_len_next;

    logic [WORD_W-1:0]  in_word;
    logic [LEN_W-1:0]   in_len;
    logic               ram_we;
    logic [ENTRY_W-1:0] rd_data;
    logic               issuing;
    logic               drained;
    score_t             sc;

    assign in_len  = sat_len(req.word_len);
    assign in_word = norm_word(req.word_chars, in_len);

    hnwm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DICT_DEPTH)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({in_len, in_word}),
        .raddr (issue_cnt_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    hnwm_score u_score (
        .q_word (q_word_reg),
        .q_len  (q_len_reg),
        .e_word (rd_data[WORD_W-1:0]),
        .e_len  (rd_data[ENTRY_W-1 -: LEN_W]),
        .score  (sc)
    );

    assign issuing = (state_reg != S_IDLE) && (issue_cnt_reg < count_reg);
    assign drained = !issuing && !rd_vld_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_cnt_next = issuing ? issue_cnt_reg + CNT_W'(1) : issue_cnt_reg;
        rd_vld_next    = issuing;
        best_vld_next  = best_vld_reg;
        best_next      = best_reg;
        hits_next      = hits_reg;
        emitted_next   = emitted_reg;
        out_vld_next   = 1'b0;
        out_next       = out_reg;
        q_word_next    = q_word_reg;
        q_len_next     = q_len_reg;
        ram_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    q_word_next = in_word;
                    q_len_next  = in_len;
                    case (req.req_type)
                        REQ_LOAD:
                        begin
                            out_vld_next        = 1'b1;
                            out_next.match_word = in_word;
                            out_next.match_len  = in_len;
                            out_next.last       = 1'b1;
                            if (count_reg < CNT_W'(DICT_DEPTH))
                            begin
                                ram_we          = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                out_next.status = ST_LOADED;
                            end
                            else
                            begin
                                out_next.status = ST_FULL;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next          = '0;
                            out_vld_next        = 1'b1;
                            out_next.match_word = '0;
                            out_next.match_len  = '0;
                            out_next.status     = ST_CLEARED;
                            out_next.last       = 1'b1;
                        end
                        REQ_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                out_vld_next        = 1'b1;
                                out_next.match_word = in_word;
                                out_next.match_len  = in_len;
                                out_next.status     = ST_NONE;
                                out_next.last       = 1'b1;
                            end
                            else
                            begin
                                state_next     = S_SCAN;
                                issue_cnt_next = '0;
                                best_vld_next  = 1'b0;
                                best_next      = '0;
                                hits_next      = '0;
                            end
                        end
                        default:
                        begin
                            // drop the unused request code
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_vld_reg && sc.cand)
                begin
                    if (!best_vld_reg || sc.agree > best_reg)
                    begin
                        best_vld_next = 1'b1;
                        best_next     = sc.agree;
                        hits_next     = CNT_W'(1);
                    end
                    else if (sc.agree == best_reg)
                    begin
                        hits_next = hits_reg + CNT_W'(1);
                    end
                end
                if (drained)
                begin
                    if (best_vld_reg)
                    begin
                        state_next     = S_EMIT;
                        issue_cnt_next = '0;
                        emitted_next   = '0;
                    end
                    else
                    begin
                        state_next          = S_IDLE;
                        out_vld_next        = 1'b1;
                        out_next.match_word = q_word_reg;
                        out_next.match_len  = q_len_reg;
                        out_next.status     = ST_NONE;
                        out_next.last       = 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (rd_vld_reg && sc.cand && sc.agree == best_reg)
                begin
                    emitted_next        = emitted_reg + CNT_W'(1);
                    out_vld_next        = 1'b1;
                    out_next.match_word = rd_data[WORD_W-1:0];
                    out_next.match_len  = rd_data[ENTRY_W-1 -: LEN_W];
                    out_next.status     = (hits_reg == CNT_W'(1)) ? ST_SINGLE : ST_SEVERAL;
                    out_next.last       = (emitted_reg + CNT_W'(1)) == hits_reg;
                end
                if (drained)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_cnt_reg <= '0;
            rd_vld_reg    <= 1'b0;
            best_vld_reg  <= 1'b0;
            hits_reg      <= '0;
            emitted_reg   <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            best_vld_reg  <= best_vld_next;
            hits_reg      <= hits_next;
            emitted_reg   <= emitted_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg   <= best_next;
        out_reg    <= out_next;
        q_word_reg <= q_word_next;
        q_len_reg  <= q_len_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule

[hdl/hnwm_checker.sv]
// ---------------------------------------------------------------------------
// hnwm_checker
// Port-level checks on the matcher's result sequencing.
// ---------------------------------------------------------------------------
module hnwm_checker
    import hnwm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input req_t    req,
    input logic    result_valid,
    input result_t result
);

    // Load transfer answers on the very next cycle with a final result.
    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.req_type == REQ_LOAD |=>
            result_valid && result.last &&
            (result.status == ST_LOADED || result.status == ST_FULL))
        else $error("load transfer without loaded/full result");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.req_type == REQ_CLEAR |=>
            result_valid && result.last && result.status == ST_CLEARED &&
            result.match_len == '0)
        else $error("clear transfer without cleared result");

    a_unused_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.req_type == REQ_UNUSED |=> !result_valid)
        else $error("unused request produced a result");

    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_SINGLE || result.status == ST_NONE) |->
            result.last)
        else $error("single or no-match result not marked last");

endmodule

bind hamming_nearest_word_match hnwm_checker u_hnwm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result)
);
